// ----- hw/rtl/dual_slot_eeprom_shadow_manager_unit_defines.svh -----
// Assertion macros shared by the checker.
`ifndef DUAL_SLOT_EEPROM_SHADOW_MANAGER_UNIT_DEFINES_SVH
`define DUAL_SLOT_EEPROM_SHADOW_MANAGER_UNIT_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define DSE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define DSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/dse_pkg.sv -----
`timescale 1ns / 1ps
package dse_pkg;
   localparam logic [2:0] FUNC_READ    = 3'd0;
   localparam logic [2:0] FUNC_WRITE   = 3'd1;
   localparam logic [2:0] FUNC_PRELOAD = 3'd2;
   localparam logic [2:0] FUNC_COMMIT  = 3'd3;
   localparam logic [2:0] FUNC_SELECT  = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_BUSY  = 2'd2;
   localparam logic [1:0] ST_CLEAN = 2'd3;

   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_ERASE   = 3'd1;
   localparam logic [2:0] ACT_PROGRAM = 3'd2;
   localparam logic [2:0] ACT_DONE    = 3'd3;
   localparam logic [2:0] ACT_ABORT   = 3'd4;

   localparam logic [1:0] SLOT_NONE = 2'd0;
   localparam logic [1:0] SLOT_A    = 2'd1;
   localparam logic [1:0] SLOT_B    = 2'd2;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_PROG = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] MAGIC     = 32'h3150_4545;
   localparam logic [12:0] SIZE_RST  = 13'd4096;
   localparam logic [7:0]  CSR_IMAGE_SIZE = 8'd0;

   typedef enum logic [3:0] {
      S_IDLE, S_ACC, S_RDWAIT, S_CRC_RD, S_CRC_WAIT, S_CRC_BIT,
      S_WORD_RD, S_WORD_WAIT, S_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic [7:0] data;
   } crc_ctl_type;

   // One bit of reflected CRC-32.
   function automatic logic [31:0] crc_bit(input logic [31:0] c);
      crc_bit = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
   endfunction
endpackage

// ----- hw/rtl/dse_ram.sv -----
`timescale 1ns / 1ps
module dse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ----- hw/rtl/dse_crc.sv -----
`timescale 1ns / 1ps
module dse_crc (
   input  logic                 clock,
   input  logic                 init,
   input  dse_pkg::crc_ctl_type ctl,
   input  logic                 step,
   output logic [31:0]          crc
);
   import dse_pkg::*;
   logic [31:0] crc_ff, crc_in;
   always_comb begin
      crc_in = crc_ff;
      if (init) crc_in = CRC_INIT;
      else if (ctl.load) crc_in = crc_ff ^ {24'd0, ctl.data};
      else if (step) crc_in = crc_bit(crc_ff);
   end
   always_ff @(posedge clock) crc_ff <= crc_in;
   assign crc = ~crc_ff;
endmodule

// ----- hw/rtl/dual_slot_eeprom_shadow_manager_unit.sv -----
`timescale 1ns / 1ps
// Path from request transfer to rsp_tvalid: a byte read goes S_ACC, S_RDWAIT (RAM registered read),
// S_OUT; write/preload/select/refused/clean/abort/done go S_ACC, S_OUT. Commit start runs a CRC pass
// over the image (per byte one RAM read, one load, eight bit steps of the CRC unit) before S_OUT.
// Program-word steps: header words go S_ACC, S_WORD_WAIT, S_OUT; data words take four byte reads.
// Input is held off while a result waits; the next transfer can be taken in the cycle after the
// result transfer. Synchronous active-high reset clears control state, not the shadow RAM.
module dual_slot_eeprom_shadow_manager_unit #(
   parameter int SHADOW_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: func[2:0] base[14:3] span[30:15] offset[46:31] wdata[54:47]
   //        prev_ok[55] valid_a[56] valid_b[57] seq_a[89:58] seq_b[121:90]
   input  logic [127:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status[1:0] read_data[9:2] action[12:10] slot[14:13]
   //        word_offset[25:15] word[57:26]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dse_pkg::*;
   localparam int AW = $clog2(SHADOW_BYTES);

   // Decode the request fields.
   logic [2:0]  f_func;  logic [11:0] f_base;
   logic [15:0] f_span, f_off;  logic [7:0] f_wdata;
   logic f_ok, f_va, f_vb;  logic [31:0] f_sa, f_sb;
   assign f_func = req_tdata[2:0];   assign f_base = req_tdata[14:3];
   assign f_span = req_tdata[30:15]; assign f_off = req_tdata[46:31];
   assign f_wdata = req_tdata[54:47]; assign f_ok = req_tdata[55];
   assign f_va = req_tdata[56]; assign f_vb = req_tdata[57];
   assign f_sa = req_tdata[89:58]; assign f_sb = req_tdata[121:90];

   state_type state_ff, state_in;
   logic [12:0] size_ff, size_in;
   logic [1:0]  active_ff, active_in, phase_ff, phase_in, target_ff, target_in;
   logic [31:0] seq_ff, seq_in;
   logic        dirty_ff, dirty_in;
   logic [10:0] widx_ff, widx_in;
   logic [12:0] csize_ff, csize_in;
   logic [31:0] icrc_ff, icrc_in;
   // Latched item.
   logic [2:0]  func_ff, func_in;  logic [16:0] addr_ff, addr_in;
   logic [7:0]  wd_ff, wd_in;  logic ok_ff, ok_in, va_ff, va_in, vb_ff, vb_in;
   logic [31:0] sa_ff, sa_in, sb_ff, sb_in;
   // Work counters.
   logic [12:0] cnt_ff, cnt_in;  logic [2:0] bit_ff, bit_in;
   logic [1:0]  k_ff, k_in;  logic [31:0] word_ff, word_in;
   // Result register.
   logic        ov_ff, ov_in;  logic [57:0] rsp_ff, rsp_in;  logic last_ff, last_in;

   logic        ram_we; logic [AW-1:0] ram_waddr, ram_raddr; logic [7:0] ram_rd;
   logic        crc_init, crc_step; crc_ctl_type crc_ctl; logic [31:0] crc_val;
   logic [12:0] eff;  logic busy;  logic [16:0] bsum, pos;

   dse_ram #(.WIDTH(8), .DEPTH(SHADOW_BYTES)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(wd_ff),
      .raddr(ram_raddr), .rdata(ram_rd));
   dse_crc u_crc (.clock(clock), .init(crc_init), .ctl(crc_ctl), .step(crc_step),
      .crc(crc_val));

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_IMAGE_SIZE[1:0]) ? {19'd0, size_ff} : 32'd0;
   assign eff = (32'(size_ff) > SHADOW_BYTES) ? 13'(SHADOW_BYTES) : size_ff;
   assign busy = (phase_ff == PH_PROG) || (phase_ff == PH_DONE);
   assign bsum = 17'(f_base) + 17'(f_span);
   assign pos = {4'd0, widx_ff - 11'd4, 2'd0} + 17'(k_ff);
   assign req_tready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {6'd0, rsp_ff};
   assign rsp_tlast = last_ff;

   // Pack one result.
   function automatic logic [57:0] pk(logic [1:0] st, logic [7:0] rd, logic [2:0] ac,
         logic [1:0] sl, logic [10:0] wo, logic [31:0] w);
      pk = {w, wo, sl, ac, rd, st};
   endfunction

   always_comb begin
      state_in = state_ff; size_in = size_ff; active_in = active_ff;
      phase_in = phase_ff; target_in = target_ff; seq_in = seq_ff;
      dirty_in = dirty_ff; widx_in = widx_ff; csize_in = csize_ff; icrc_in = icrc_ff;
      func_in = func_ff; addr_in = addr_ff; wd_in = wd_ff; ok_in = ok_ff;
      va_in = va_ff; vb_in = vb_ff; sa_in = sa_ff; sb_in = sb_ff;
      cnt_in = cnt_ff; bit_in = bit_ff; k_in = k_ff; word_in = word_ff;
      ov_in = ov_ff; rsp_in = rsp_ff; last_in = last_ff;
      ram_we = 1'b0; ram_waddr = addr_ff[AW-1:0]; ram_raddr = addr_ff[AW-1:0];
      crc_init = 1'b0; crc_step = 1'b0; crc_ctl = '{load: 1'b0, data: ram_rd};
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_IMAGE_SIZE[1:0])
         size_in = csr_pwdata[12:0];
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               func_in = f_func; wd_in = f_wdata; ok_in = f_ok; va_in = f_va;
               vb_in = f_vb; sa_in = f_sa; sb_in = f_sb;
               addr_in = 17'(f_base) + {1'b0, f_off};
               // Range check at accept: the out-of-range flag is stored in cnt bit 0.
               cnt_in = ((bsum > 17'(eff)) || (f_off >= f_span)) ? 13'd1 : 13'd0;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = S_OUT; last_in = 1'b0;
            rsp_in = pk(ST_OK, 8'd0, ACT_NONE, SLOT_NONE, 11'd0, 32'd0);
            case (func_ff)
               FUNC_READ, FUNC_WRITE, FUNC_PRELOAD: begin
                  if (func_ff != FUNC_READ && busy) rsp_in[1:0] = ST_BUSY;
                  else if (cnt_ff[0]) rsp_in[1:0] = ST_RANGE;
                  else if (func_ff == FUNC_READ) state_in = S_RDWAIT;
                  else begin
                     ram_we = 1'b1;
                     if (func_ff == FUNC_WRITE) dirty_in = 1'b1;
                  end
               end
               FUNC_COMMIT: begin
                  if (!busy) begin
                     if (!dirty_ff) rsp_in[1:0] = ST_CLEAN;
                     else begin
                        csize_in = eff; crc_init = 1'b1; cnt_in = 13'd0;
                        target_in = (active_ff == SLOT_A) ? SLOT_B : SLOT_A;
                        widx_in = 11'd0; phase_in = PH_PROG;
                        state_in = S_CRC_RD;
                     end
                  end else if (!ok_ff) begin
                     rsp_in = pk(ST_OK, 8'd0, ACT_ABORT, target_ff, 11'd0, 32'd0);
                     phase_in = PH_IDLE;
                  end else if (phase_ff == PH_PROG) begin
                     k_in = 2'd0;
                     case (widx_ff)
                        11'd0: word_in = MAGIC;
                        11'd1: word_in = seq_ff + 32'd1;
                        11'd2: word_in = {19'd0, csize_ff};
                        11'd3: word_in = icrc_ff;
                        default: word_in = 32'hFFFF_FFFF;
                     endcase
                     state_in = (widx_ff < 11'd4) ? S_WORD_WAIT : S_WORD_RD;
                     cnt_in = 13'd4;
                  end else begin
                     rsp_in = pk(ST_OK, 8'd0, ACT_DONE, target_ff, 11'd0, 32'd0);
                     seq_in = seq_ff + 32'd1; active_in = target_ff;
                     dirty_in = 1'b0; phase_in = PH_IDLE;
                  end
               end
               FUNC_SELECT: begin
                  if (busy) rsp_in[1:0] = ST_BUSY;
                  else begin
                     dirty_in = 1'b0;
                     if (va_ff && (!vb_ff || sa_ff >= sb_ff)) begin
                        active_in = SLOT_A; seq_in = sa_ff;
                     end else if (vb_ff) begin
                        active_in = SLOT_B; seq_in = sb_ff;
                     end else begin
                        active_in = SLOT_NONE; seq_in = 32'd0;
                     end
                     rsp_in[14:13] = active_in;
                  end
               end
               default: ;
            endcase
         end
         S_RDWAIT: begin
            rsp_in[9:2] = ram_rd; state_in = S_OUT;
         end
         S_CRC_RD: begin
            // Issue one byte read, or finish the pass.
            ram_raddr = cnt_ff[AW-1:0];
            if (cnt_ff >= csize_ff) begin
               icrc_in = crc_val; state_in = S_OUT;
               rsp_in = pk(ST_OK, 8'd0, ACT_ERASE, target_ff, 11'd0, 32'd0);
            end else state_in = S_CRC_WAIT;
         end
         S_CRC_WAIT: begin
            crc_ctl.load = 1'b1; bit_in = 3'd0; state_in = S_CRC_BIT;
         end
         S_CRC_BIT: begin
            crc_step = 1'b1; bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               cnt_in = cnt_ff + 13'd1; state_in = S_CRC_RD;
            end
         end
         S_WORD_RD: begin
            ram_raddr = pos[AW-1:0];
            if (pos >= 17'(csize_ff)) state_in = S_WORD_WAIT;
            else begin
               state_in = S_WORD_WAIT; cnt_in = {11'd0, k_ff};
            end
         end
         S_WORD_WAIT: begin
            if (widx_ff >= 11'd4 && pos < 17'(csize_ff))
               word_in[8*k_ff +: 8] = ram_rd;
            if (widx_ff >= 11'd4 && k_ff != 2'd3) begin
               k_in = k_ff + 2'd1; state_in = S_WORD_RD;
            end else begin
               state_in = S_OUT;
               rsp_in = pk(ST_OK, 8'd0, ACT_PROGRAM, target_ff, widx_ff, word_in);
               // Last when index+1 reaches header plus data words.
               if (13'(widx_ff) + 13'd1 >= 13'd4 + ((csize_ff + 13'd3) >> 2)) begin
                  last_in = 1'b1; phase_in = PH_DONE;
               end
               widx_in = widx_ff + 11'd1;
            end
         end
         S_OUT: begin
            ov_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; size_ff <= SIZE_RST; active_ff <= SLOT_NONE;
         phase_ff <= PH_IDLE; target_ff <= SLOT_NONE; seq_ff <= '0; dirty_ff <= 1'b0;
         widx_ff <= '0; csize_ff <= '0; icrc_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; size_ff <= size_in; active_ff <= active_in;
         phase_ff <= phase_in; target_ff <= target_in; seq_ff <= seq_in;
         dirty_ff <= dirty_in; widx_ff <= widx_in; csize_ff <= csize_in;
         icrc_ff <= icrc_in; ov_ff <= ov_in;
      end
      func_ff <= func_in; addr_ff <= addr_in; wd_ff <= wd_in; ok_ff <= ok_in;
      va_ff <= va_in; vb_ff <= vb_in; sa_ff <= sa_in; sb_ff <= sb_in;
      cnt_ff <= cnt_in; bit_ff <= bit_in; k_ff <= k_in; word_ff <= word_in;
      rsp_ff <= rsp_in; last_ff <= last_in;
   end
endmodule

// ----- hw/rtl/dse_checker.sv -----
`timescale 1ns / 1ps
`include "dual_slot_eeprom_shadow_manager_unit_defines.svh"
module dse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);
   import dse_pkg::*;
   `DSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped while stalled")
   `DSE_ASSERT_IMPL(a_no_accept_with_rsp, clock, reset, rsp_tvalid, !req_tready, "item taken while a result waits")
   `DSE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "ready stayed high after a transfer")
   `DSE_ASSERT_IMPL(a_last_program, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[12:10] == ACT_PROGRAM, "last on a non-program result")
endmodule
bind dual_slot_eeprom_shadow_manager_unit dse_checker u_dse_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast));

// ----- tb/sv/dse_shadow_checker.sv -----
`timescale 1ns / 1ps
module dse_shadow_checker
   import dse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           pending,
   output int           fails
);
   localparam int DEPTH = 4096;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  rdata;
      logic [2:0]  action;
      logic [1:0]  slot;
      logic [10:0] woff;
      logic [31:0] word;
      logic        last;
   } outcome_t;

   outcome_t    outcome_q[$];
   logic [7:0]  shadow [DEPTH];
   logic [12:0] size_reg;
   logic [1:0]  act_slot, target, phase;
   logic [31:0] seq, crc;
   logic        dirty;
   logic [10:0] widx;
   int unsigned csize;
   int          nfail;

   initial begin
      for (int i = 0; i < DEPTH; i++) shadow[i] = 8'h00;
      nfail = 0;
   end

   function automatic int unsigned eff_size();
      return (size_reg > DEPTH) ? DEPTH : size_reg;
   endfunction

   function automatic logic [31:0] image_crc(int unsigned n);
      logic [31:0] c;
      c = CRC_INIT;
      for (int unsigned i = 0; i < n; i++) begin
         c ^= {24'h0, shadow[i]};
         for (int b = 0; b < 8; b++) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return ~c;
   endfunction

   function automatic logic [31:0] slot_word(int unsigned idx);
      logic [31:0] w;
      int unsigned pos;
      w = '0;
      if (idx == 0) return MAGIC;
      if (idx == 1) return seq + 32'd1;
      if (idx == 2) return csize;
      if (idx == 3) return crc;
      pos = (idx - 4) * 4;
      for (int k = 0; k < 4; k++)
         w[8*k +: 8] = (pos + k < csize) ? shadow[pos + k] : 8'hFF;
      return w;
   endfunction

   // Advance the shadow state by one request and return its response.
   function automatic outcome_t predict(logic [127:0] d);
      logic [2:0]  f;
      logic [11:0] base;
      logic [15:0] span, offs;
      logic [31:0] sa, sb;
      outcome_t    o;
      bit          busy;
      int unsigned total;
      f = d[2:0];
      base = d[14:3];
      span = d[30:15];
      offs = d[46:31];
      sa = d[89:58];
      sb = d[121:90];
      o = '{default: '0};
      busy = (phase == PH_PROG || phase == PH_DONE);
      if (f == FUNC_READ || f == FUNC_WRITE || f == FUNC_PRELOAD) begin
         if (f != FUNC_READ && busy) o.status = ST_BUSY;
         else if (int'(base) + int'(span) > eff_size() || offs >= span) o.status = ST_RANGE;
         else if (f == FUNC_READ) o.rdata = shadow[base + offs];
         else begin
            shadow[base + offs] = d[54:47];
            if (f == FUNC_WRITE) dirty = 1'b1;
         end
      end else if (f == FUNC_COMMIT) begin
         if (!busy) begin
            if (!dirty) o.status = ST_CLEAN;
            else begin
               csize = eff_size();
               crc = image_crc(csize);
               target = (act_slot == SLOT_A) ? SLOT_B : SLOT_A;
               widx = '0;
               phase = PH_PROG;
               o.action = ACT_ERASE;
               o.slot = target;
            end
         end else if (!d[55]) begin
            o.action = ACT_ABORT;
            o.slot = target;
            phase = PH_IDLE;
         end else if (phase == PH_PROG) begin
            total = 4 + (csize + 3) / 4;
            o.action = ACT_PROGRAM;
            o.slot = target;
            o.woff = widx;
            o.word = slot_word(widx);
            if (widx + 1 >= total) begin
               o.last = 1'b1;
               phase = PH_DONE;
            end
            widx++;
         end else begin
            o.action = ACT_DONE;
            o.slot = target;
            seq = seq + 32'd1;
            act_slot = target;
            dirty = 1'b0;
            phase = PH_IDLE;
         end
      end else if (f == FUNC_SELECT) begin
         if (busy) o.status = ST_BUSY;
         else begin
            if (d[56] && (!d[57] || sa >= sb)) begin
               act_slot = SLOT_A;
               seq = sa;
            end else if (d[57]) begin
               act_slot = SLOT_B;
               seq = sb;
            end else begin
               act_slot = SLOT_NONE;
               seq = '0;
            end
            dirty = 1'b0;
            o.slot = act_slot;
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_t e, a;
      if (reset) begin
         size_reg = SIZE_RST;
         act_slot = SLOT_NONE;
         seq = '0;
         dirty = 1'b0;
         phase = PH_IDLE;
         widx = '0;
         crc = '0;
         target = SLOT_NONE;
         csize = 0;
         outcome_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CSR_IMAGE_SIZE[1:0])
            size_reg = csr_pwdata[12:0];
         if (req_tvalid && req_tready) outcome_q.push_back(predict(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            a.status = rsp_tdata[1:0];
            a.rdata = rsp_tdata[9:2];
            a.action = rsp_tdata[12:10];
            a.slot = rsp_tdata[14:13];
            a.woff = rsp_tdata[25:15];
            a.word = rsp_tdata[57:26];
            a.last = rsp_tlast;
            if (outcome_q.size() == 0) begin
               nfail++;
               if (nfail <= 10) $display("%0t: unexpected response %p", $realtime, a);
            end else begin
               e = outcome_q.pop_front();
               if (a != e) begin
                  nfail++;
                  if (nfail <= 10)
                     $display("%0t: mismatch\n  exp %p\n  got %p", $realtime, e, a);
               end
            end
         end
      end
      pending <= outcome_q.size();
      fails <= nfail;
   end
endmodule

// ----- tb/sv/dual_slot_eeprom_shadow_manager_unit_tb.sv -----
`timescale 1ns / 1ps
module dual_slot_eeprom_shadow_manager_unit_tb;
   import dse_pkg::*;

   // One request as the stimulus side sees it, before packing into tdata.
   typedef struct {
      logic [2:0]  func;
      logic [11:0] base;
      logic [15:0] span;
      logic [15:0] offs;
      logic [7:0]  wdata;
      logic        ok;
      logic        va;
      logic        vb;
      logic [31:0] sa;
      logic [31:0] sb;
   } access_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // tdata: func, base, span, offset, wdata, prev_ok, valid_a, valid_b, seq_a, seq_b
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // tdata: status, read_data, action, slot, word_offset, word
   logic [63:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [1:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           pending, fails;

   // Stimulus-side mirror: which bytes hold data, and whether a commit runs.
   bit          written [4096];
   int          cur_size = 4096;
   bit          dirty, committing;
   int          words_left;
   int          items, commits, aborts, cleans;
   bit          calm, hold_req, hold_served;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   dual_slot_eeprom_shadow_manager_unit dut (.*);

   dse_shadow_checker chk (.*);

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_served) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_served = 1'b1;
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic bit in_range(access_t a);
      return int'(a.base) + int'(a.span) <= cur_size && a.offs < a.span;
   endfunction

   function automatic bit all_written();
      for (int i = 0; i < cur_size; i++) if (!written[i]) return 0;
      return 1;
   endfunction

   function automatic access_t rand_access();
      access_t a;
      a.func = 3'($urandom_range(0, 7));
      a.base = 12'($urandom);
      a.span = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
      a.offs = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
      a.wdata = 8'($urandom);
      a.ok = 1'($urandom_range(0, 1));
      a.va = 1'($urandom_range(0, 1));
      a.vb = 1'($urandom_range(0, 1));
      a.sa = $urandom;
      a.sb = ($urandom_range(0, 3) == 0) ? a.sa : 32'($urandom);
      return a;
   endfunction

   // Drop valid and let the request side rest for a while.
   task automatic rest(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Hold off until every response is back, then let a trailing pass settle.
   task automatic drain();
      rest(1);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Offer one request and wait for its transfer; keep the mirror current.
   task automatic send(access_t a);
      // Never start a commit over an image with bytes that were never stored.
      if (a.func == FUNC_COMMIT && !committing && dirty && !all_written())
         a.func = FUNC_READ;
      // Never read a byte that was never stored.
      if (a.func == FUNC_READ && in_range(a) && !written[a.base + a.offs])
         a.func = FUNC_PRELOAD;
      if (!calm && $urandom_range(0, 4) == 0) rest($urandom_range(1, 9));
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, a.sb, a.sa, a.vb, a.va, a.ok, a.wdata, a.offs, a.span,
                    a.base, a.func};
      do @(posedge clock); while (!req_tready);
      items++;
      if (a.func == FUNC_READ || a.func == FUNC_WRITE || a.func == FUNC_PRELOAD) begin
         if (!(a.func != FUNC_READ && committing) && in_range(a)) begin
            if (a.func != FUNC_READ) written[a.base + a.offs] = 1'b1;
            if (a.func == FUNC_WRITE) dirty = 1'b1;
         end
      end else if (a.func == FUNC_COMMIT) begin
         if (!committing) begin
            if (dirty) begin
               committing = 1'b1;
               commits++;
               words_left = 4 + (cur_size + 3) / 4;
            end else cleans++;
         end else if (!a.ok) begin
            committing = 1'b0;
            aborts++;
         end else if (words_left > 0) words_left--;
         else begin
            committing = 1'b0;
            dirty = 1'b0;
         end
      end else if (a.func == FUNC_SELECT && !committing) dirty = 1'b0;
   endtask

   task automatic access(logic [2:0] f, int base, int span, int offs, int wd);
      access_t a;
      a = rand_access();
      a.func = f;
      a.base = 12'(base);
      a.span = 16'(span);
      a.offs = 16'(offs);
      a.wdata = 8'(wd);
      send(a);
   endtask

   task automatic pick(bit va, bit vb, logic [31:0] sa, logic [31:0] sb);
      access_t a;
      a = rand_access();
      a.func = FUNC_SELECT;
      a.va = va;
      a.vb = vb;
      a.sa = sa;
      a.sb = sb;
      send(a);
   endtask

   task automatic set_size(int v);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_IMAGE_SIZE[1:0];
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_size = (v > 4096) ? 4096 : v;
   endtask

   // Well-formed byte transfer: every offset of one base/span in order.
   task automatic burst();
      int span, base, r;
      logic [2:0] f;
      r = $urandom_range(0, 9);
      f = (r < 4) ? FUNC_READ : (r < 8) ? FUNC_WRITE : FUNC_PRELOAD;
      span = $urandom_range(1, (cur_size < 8) ? cur_size : 8);
      base = $urandom_range(0, cur_size - span);
      for (int i = 0; i < span; i++) access(f, base, span, i, $urandom);
      // Now and then run one offset past the end.
      if ($urandom_range(0, 9) == 0) access(f, base, span, span, $urandom);
   endtask

   // Fill the image if needed (sizes up to 256 only), then step a commit through to done or abort.
   task automatic commit_run();
      access_t a;
      if (cur_size > 256 && !all_written()) return;
      for (int i = 0; i < cur_size; i++)
         if (!written[i]) access(FUNC_PRELOAD, i, 1, 0, $urandom);
      if ($urandom_range(0, 1) == 0) access(FUNC_WRITE, 0, 1, 0, $urandom);
      a = rand_access();
      a.func = FUNC_COMMIT;
      send(a);
      while (committing) begin
         // Busy-side traffic: reads served, writes, preloads and selects refused as busy.
         if ($urandom_range(0, 5) == 0) begin
            a = rand_access();
            if (a.func == FUNC_COMMIT) a.func = FUNC_READ;
            send(a);
         end
         a = rand_access();
         a.func = FUNC_COMMIT;
         a.ok = ($urandom_range(0, 59) != 0);
         send(a);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, range failures, select rules, odd codes.
      access(FUNC_PRELOAD, 0, 4, 0, 8'h00);
      access(FUNC_PRELOAD, 0, 4, 1, 8'hFF);
      access(FUNC_PRELOAD, 0, 4, 2, 8'h5A);
      access(FUNC_PRELOAD, 0, 4, 3, 8'hA5);
      access(FUNC_READ, 0, 4, 1, 0);
      access(FUNC_READ, 0, 4, 2, 0);
      access(FUNC_WRITE, 4095, 1, 0, 8'hFF);
      access(FUNC_READ, 4095, 1, 0, 0);
      access(FUNC_READ, 4095, 2, 0, 0);
      access(FUNC_WRITE, 10, 0, 0, 8'h11);
      access(FUNC_PRELOAD, 0, 65535, 65535, 8'h22);
      access(FUNC_READ, 2, 3, 3, 0);
      pick(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      pick(1, 1, 32'd1, 32'd2);
      pick(0, 1, 32'd9, 32'd7);
      pick(1, 0, 32'd0, 32'hFFFF_FFFF);
      pick(0, 0, 32'd5, 32'd6);
      access(FUNC_COMMIT, 0, 0, 0, 0);
      for (int f = 5; f < 8; f++) access(3'(f), $urandom, $urandom, $urandom, $urandom);

      // Random phases, each at its own image size, extremes included.
      for (int p = 0; p < 7; p++) begin
         int sizes[7];
         int r;
         sizes = '{1, 8191, 64, 4096, 13, 256, 97};
         set_size(sizes[p]);
         if (p == 2) hold_req = 1'b1;
         while (items < 140 * (p + 1)) begin
            if (items > 860) calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 50) burst();
            else if (r < 60) commit_run();
            else if (r < 70) pick($urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom, ($urandom_range(0, 1) ? 32'($urandom) : 32'd0));
            else send(rand_access());
         end
         if (p == 4) drain();
      end

      drain();
      repeat (60) @(posedge clock);
      $display("Sent %0d requests across 7 image sizes; %0d commits started, %0d aborted,",
               items, commits, aborts);
      $display("%0d refused as clean; long response hold-off and full drains exercised.",
               cleans);
      if (fails == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ----- dual_slot_eeprom_shadow_manager_unit.f -----
+incdir+hw/rtl
hw/rtl/dse_pkg.sv
hw/rtl/dse_ram.sv
hw/rtl/dse_crc.sv
hw/rtl/dual_slot_eeprom_shadow_manager_unit.sv
hw/rtl/dse_checker.sv
tb/sv/dse_shadow_checker.sv
tb/sv/dual_slot_eeprom_shadow_manager_unit_tb.sv
